FILE: src/ppse_pkg.sv
// Package for the piecewise polynomial spline evaluator.
// Holds payload structs, sequencer states, table sizes and the Horner weight function.
// No dependencies.
package ppse_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int MAX_DEGREE   = 5;
    localparam int SEG_W        = 4;
    localparam int NUM_COEF     = MAX_DEGREE + 1;
    localparam int COEF_AW      = 7;   // segment * 6 + power fits below 128
    localparam int POW_W        = 3;
    localparam int CNT_W        = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [2:0] WORD_START = 3'd0;
    localparam logic [2:0] WORD_END   = 3'd1;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               operation;
        logic [3:0]         segment_index;
        logic [2:0]         word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] query_time;
        logic [1:0]         derivative_order;
        logic               wrap_to_unit;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0]         chosen_segment;
        logic               table_empty;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_EDGE,
        ST_CLAMP,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DT_RD,
        ST_DT,
        ST_H_RD,
        ST_H_MUL,
        ST_H_ADD,
        ST_OUT
    } t_state;

    // Weight i!/(i-d)! for power i and derivative order d; zero when i < d.
    function automatic logic [6:0] horner_weight(input logic [2:0] i, input logic [1:0] d);
        logic [6:0] w;
        w = 7'd1;
        for (int k = 0; k < 3; k++) begin
            if (k < int'(d)) begin
                w = 7'(w * 7'(int'(i) - k));
            end
        end
        return w;
    endfunction

endpackage

FILE: src/ppse_table.sv
// Segment table memories: starts, ends and coefficients, one read port each.
// Depends on ppse_pkg.
module ppse_table
    import ppse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [SEG_W-1:0]    i_wr_seg,
    input  logic [2:0]          i_wr_word,
    input  logic signed [31:0]  i_wr_data,
    input  logic [SEG_W-1:0]    i_rd_seg,
    input  logic [POW_W-1:0]    i_rd_pow,
    output logic signed [31:0]  o_start,
    output logic signed [31:0]  o_end,
    output logic signed [31:0]  o_coef
);

    logic signed [31:0] r_start [MAX_SEGMENTS];
    logic signed [31:0] r_end   [MAX_SEGMENTS];
    logic signed [31:0] r_coef  [MAX_SEGMENTS*NUM_COEF];

    logic [COEF_AW-1:0] wr_caddr;
    logic [COEF_AW-1:0] rd_caddr;
    logic [POW_W-1:0]   wr_pow;

    assign wr_pow   = i_wr_word - 3'd2;
    assign wr_caddr = COEF_AW'(i_wr_seg) * COEF_AW'(NUM_COEF) + COEF_AW'(wr_pow);
    assign rd_caddr = COEF_AW'(i_rd_seg) * COEF_AW'(NUM_COEF) + COEF_AW'(i_rd_pow);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_word == WORD_START) begin
                r_start[i_wr_seg] <= i_wr_data;
            end else if (i_wr_word == WORD_END) begin
                r_end[i_wr_seg] <= i_wr_data;
            end else if (int'(wr_pow) <= MAX_DEGREE) begin
                r_coef[wr_caddr] <= i_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_start <= r_start[i_rd_seg];
        o_end   <= r_end[i_rd_seg];
        o_coef  <= r_coef[rd_caddr];
    end

endmodule

FILE: src/ppse_mac.sv
// Shared multiply unit: rounded Q16.16 product of two 32-bit operands, registered.
// Depends on ppse_pkg.
module ppse_mac
    import ppse_pkg::*;
(
    input  logic                i_clk,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output logic signed [47:0]  o_prod
);

    logic signed [63:0] prod;

    // Adding half an LSB and shifting arithmetically gives round half up.
    assign prod = 64'(i_a) * 64'(i_b) + 64'sh8000;

    always_ff @(posedge i_clk) begin
        o_prod <= prod[63:16];
    end

endmodule

FILE: src/piecewise_polynomial_spline_eval_core.sv
// Top level of the piecewise polynomial spline evaluator.
// Depends on ppse_pkg, ppse_table and ppse_mac.
//
// Usage: input words arrive on i_in_valid/o_in_ready with a t_in_word payload.
// A word with operation set to write stores one table word and
// gives no result. An evaluate word produces one t_out_word on
// o_out_valid/i_out_ready. The user must write the segment count register
// through i_cfg_we/i_cfg_data while the block is idle (not enforced).
// Steps of an evaluate word up to o_out_valid: the wrap is done as the word
// is taken; an edge read and a clamp state, run for the first start and then
// the last end, clamp it to them; each binary search step has a read and a
// compare state (up to four steps for sixteen segments), and a last read
// ends the search; a read and an offset state form the offset; each Horner
// step has a read, a multiply and an add state (six to three steps for
// derivative order 0 to 3) with the one shared multiplier; the output state
// loads the output register. An empty table goes straight to the output state.
// The sequencer handles one word at a time and o_in_ready is low while it
// works. Each table memory has one read port, so each step has a read state.
// Reset clears the sequencer, the output valid and the segment count; table
// contents are undefined until written. If the receiver stalls, the result
// stays in the output register and the block accepts nothing further until
// it is taken.
module piecewise_polynomial_spline_eval_core
    import ppse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [SEG_W:0]     r_n;        // effective count, 0..16, zero for an empty table
    logic signed [31:0] r_x;
    logic [1:0]         r_d;
    logic signed [5:0]  r_lo, r_up, r_mid;
    logic [POW_W-1:0]   r_pow;
    logic signed [31:0] r_dt;
    logic signed [31:0] r_acc;
    logic signed [47:0] r_prod_hold;
    logic               r_ovalid;
    t_out_word          r_out;

    logic [SEG_W-1:0]   rd_seg;
    logic signed [31:0] tb_start, tb_end, tb_coef;
    logic signed [47:0] prod;
    logic               accept;
    logic signed [5:0]  mid_calc;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    // The read address is chosen by the phase of the sequencer. A search step
    // reads the new midpoint; the offset and Horner phases read the chosen
    // segment, with a negative index raised to the first segment.
    always_comb begin
        rd_seg = r_mid[SEG_W-1:0];
        if (r_state == ST_RD_EDGE) begin
            rd_seg = (r_pow == 3'd0) ? '0 : SEG_W'(r_n - 1'b1);
        end else if (r_state == ST_SRCH_RD) begin
            rd_seg = mid_calc[SEG_W-1:0];
        end else if (r_state == ST_DT_RD) begin
            rd_seg = r_up[5] ? '0 : r_up[SEG_W-1:0];
        end else if (r_state == ST_DT || r_state == ST_H_RD || r_state == ST_H_MUL ||
                     r_state == ST_H_ADD) begin
            rd_seg = r_up[SEG_W-1:0];
        end
    end

    ppse_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && i_in_word.operation == OP_WRITE),
        .i_wr_seg  (i_in_word.segment_index),
        .i_wr_word (i_in_word.word_index),
        .i_wr_data (i_in_word.word_value),
        .i_rd_seg  (rd_seg),
        .i_rd_pow  (r_pow),
        .o_start   (tb_start),
        .o_end     (tb_end),
        .o_coef    (tb_coef)
    );

    ppse_mac u_mac (
        .i_clk  (i_clk),
        .i_a    (r_acc),
        .i_b    (r_dt),
        .o_prod (prod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (accept && i_in_word.operation == OP_EVAL) begin
                             n_state = (r_count == '0) ? ST_OUT : ST_RD_EDGE;
                         end
            ST_RD_EDGE:  n_state = ST_CLAMP;
            ST_CLAMP:    n_state = (r_pow == 3'd0) ? ST_RD_EDGE : ST_SRCH_RD;
            ST_SRCH_RD:  n_state = (r_lo < r_up) ? ST_SRCH_CMP : ST_DT_RD;
            ST_SRCH_CMP: n_state = ST_SRCH_RD;
            ST_DT_RD:    n_state = ST_DT;
            ST_DT:       n_state = ST_H_RD;
            ST_H_RD:     n_state = ST_H_MUL;
            ST_H_MUL:    n_state = ST_H_ADD;
            ST_H_ADD:    n_state = (r_pow == 3'(r_d)) ? ST_OUT : ST_H_RD;
            ST_OUT:      n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath values used by several phases.
    logic signed [32:0] dt_full;
    logic signed [48:0] sum;
    logic signed [39:0] wc;
    logic signed [31:0] wrap_x;

    assign dt_full  = 33'(r_x) - 33'(tb_start);
    assign wc       = 40'(tb_coef) * $signed({1'b0, horner_weight(r_pow, r_d)});
    assign sum      = 49'(r_prod_hold) + 49'(wc);
    assign mid_calc = 6'((7'(r_lo) + 7'(r_up)) >>> 1);

    always_comb begin
        wrap_x = i_in_word.query_time;
        if (i_in_word.wrap_to_unit) begin
            if (i_in_word.query_time < 0) begin
                wrap_x = Q_ONE - {16'd0, 16'(-i_in_word.query_time)};
            end else if (i_in_word.query_time > Q_ONE) begin
                wrap_x = {16'd0, i_in_word.query_time[15:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_state == ST_OUT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x   <= wrap_x;
                r_d   <= i_in_word.derivative_order;
                r_pow <= 3'd0;
                r_n   <= (r_count > 5'(MAX_SEGMENTS)) ? 5'(MAX_SEGMENTS) : r_count;
                r_acc <= '0;
                r_up  <= '0;
            end
            ST_CLAMP: begin
                if (r_pow == 3'd0) begin
                    if (r_x <= tb_start) r_x <= tb_start;
                    r_pow <= 3'd1;
                end else begin
                    if (r_x >= tb_end) r_x <= tb_end;
                    r_lo  <= '0;
                    r_up  <= 6'(r_n) - 6'sd1;
                    r_mid <= 6'((6'(r_n) - 6'sd1) >>> 1);
                end
            end
            ST_SRCH_RD: r_mid <= mid_calc;
            ST_SRCH_CMP: begin
                if (r_x < tb_start) begin
                    r_up <= r_mid - 6'sd1;
                end else if (r_x > tb_end) begin
                    r_lo <= r_mid + 6'sd1;
                end else begin
                    r_lo <= r_mid;
                    r_up <= r_mid;
                end
            end
            ST_DT_RD: begin
                if (r_up < 0) r_up <= '0;
                r_pow <= 3'(MAX_DEGREE);
            end
            ST_DT: begin
                if (dt_full > 33'(SAT_MAX))      r_dt <= SAT_MAX;
                else if (dt_full < 33'(SAT_MIN)) r_dt <= SAT_MIN;
                else                             r_dt <= dt_full[31:0];
            end
            ST_H_MUL: ;
            ST_H_ADD: begin
                if (sum > 49'(SAT_MAX))      r_acc <= SAT_MAX;
                else if (sum < 49'(SAT_MIN)) r_acc <= SAT_MIN;
                else                         r_acc <= sum[31:0];
                r_pow <= r_pow - 3'd1;
            end
            ST_OUT: begin
                r_out.result_value   <= r_acc;
                r_out.chosen_segment <= r_up[SEG_W-1:0];
                r_out.table_empty    <= (r_count == '0);
            end
            default: ;
        endcase
        r_prod_hold <= prod;
    end

`ifndef SYNTH
    // No new word is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("accepted while result pending");
    // A result word is only raised from the output phase.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT)) else $error("stray result");
    // The chosen segment index stays below the effective count for a non-empty table.
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_count != '0) |-> (5'(r_up[SEG_W-1:0]) < r_n))
        else $error("segment out of range");
`endif

endmodule
